// ===== rtl/oct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the order-constraint transitive closure block.
package oct_pkg;

    localparam int NODE_W    = 5;
    localparam int CNT_W     = 6;
    localparam int ROW_LIMIT = 32;
    localparam int OUT_W     = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_SWEEP,
        ST_EMIT,
        ST_EMIT_WAIT
    } oct_state_t;

    // What a memory read was issued for; travels with the read to its data.
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_ARC,
        TAG_PIVOT,
        TAG_SWEEP,
        TAG_EMIT
    } oct_tag_t;

    typedef struct packed {
        logic              in_ready;
        oct_tag_t          tag;
        logic [NODE_W-1:0] addr;
        logic              clear_all;
    } oct_cmd_t;

endpackage

// ===== rtl/oct_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module oct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/oct_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer: arc loading, Warshall pivot/sweep passes and row emission.
module oct_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      has_arc,
    input  logic                      arc_ok,
    input  logic                      last_arc,
    input  logic [oct_pkg::NODE_W-1:0] from_node,
    input  logic [oct_pkg::NODE_W-1:0] nlast,
    input  logic                      out_busy,
    output oct_pkg::oct_cmd_t         cmd
);

    oct_pkg::oct_state_t state_reg, state_next;
    logic [oct_pkg::NODE_W-1:0] k_reg, k_next;
    logic [oct_pkg::NODE_W-1:0] i_reg, i_next;
    logic in_fire;

    assign in_fire = in_valid && (state_reg == oct_pkg::ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oct_pkg::ST_LOAD;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        case (state_reg)
            oct_pkg::ST_LOAD:
            begin
                if (in_fire && last_arc)
                begin
                    state_next = oct_pkg::ST_PIVOT;
                    k_next     = '0;
                end
            end
            oct_pkg::ST_PIVOT:
            begin
                state_next = oct_pkg::ST_SWEEP;
                i_next     = '0;
            end
            oct_pkg::ST_SWEEP:
            begin
                i_next = i_reg + 1'b1;
                if (i_reg == nlast)
                begin
                    if (k_reg == nlast)
                    begin
                        state_next = oct_pkg::ST_EMIT;
                        i_next     = '0;
                    end
                    else
                    begin
                        state_next = oct_pkg::ST_PIVOT;
                        k_next     = k_reg + 1'b1;
                    end
                end
            end
            oct_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    state_next = oct_pkg::ST_EMIT_WAIT;
                end
            end
            oct_pkg::ST_EMIT_WAIT:
            begin
                if (i_reg == nlast)
                begin
                    state_next = oct_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = oct_pkg::ST_EMIT;
                    i_next     = i_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = oct_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        cmd.tag       = oct_pkg::TAG_NONE;
        cmd.in_ready  = (state_reg == oct_pkg::ST_LOAD);
        case (state_reg)
            oct_pkg::ST_LOAD:
            begin
                if (in_fire && has_arc && arc_ok)
                begin
                    cmd.tag  = oct_pkg::TAG_ARC;
                    cmd.addr = from_node;
                end
            end
            oct_pkg::ST_PIVOT:
            begin
                cmd.tag  = oct_pkg::TAG_PIVOT;
                cmd.addr = k_reg;
            end
            oct_pkg::ST_SWEEP:
            begin
                cmd.tag  = oct_pkg::TAG_SWEEP;
                cmd.addr = i_reg;
            end
            oct_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.tag  = oct_pkg::TAG_EMIT;
                    cmd.addr = i_reg;
                end
            end
            oct_pkg::ST_EMIT_WAIT:
            begin
                cmd.clear_all = (i_reg == nlast);
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/order_constraint_transitive_closure.sv =====
`timescale 1ns / 1ps
// Arc requests are taken one per cycle while the block is loading; the closure starts
// after the last request. Closure for n nodes in use: n pivot passes, each one pivot
// read followed by one read-modify-write per row. Rows then leave in index order while
// the output is taken.
// Reset (rst_n, async, active low): node_count back to 32, row valid bits cleared so
// every row reads as zero; no memory clearing pass is needed.
module order_constraint_transitive_closure #(
    parameter int MAX_NODES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [oct_pkg::CNT_W-1:0]   node_count,
    // arc request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        has_arc,
    input  logic [oct_pkg::NODE_W-1:0]  from_node,
    input  logic [oct_pkg::NODE_W-1:0]  to_node,
    input  logic                        last_arc,
    // reachability row channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [oct_pkg::NODE_W-1:0]  row_index,
    output logic [oct_pkg::OUT_W-1:0]   row_bits,
    output logic                        last_row
);

    // Rows never exceed the output width, so the matrix is ROW_W by ROW_W.
    localparam int ROW_W = (MAX_NODES < oct_pkg::ROW_LIMIT) ? MAX_NODES : oct_pkg::ROW_LIMIT;
    localparam int AW    = $clog2(ROW_W);

    oct_pkg::oct_cmd_t cmd;

    logic [oct_pkg::CNT_W-1:0]  node_count_reg;
    logic [oct_pkg::NODE_W-1:0] nlast_cur;
    logic [oct_pkg::NODE_W-1:0] nlast_reg;
    logic                       arc_ok;
    logic                       in_fire;
    logic                       out_busy;

    // read side, registered in the cycle after the request
    oct_pkg::oct_tag_t          rd_tag_reg;
    logic [oct_pkg::NODE_W-1:0] rd_addr_reg;
    logic                       rd_valid_reg;
    logic [oct_pkg::NODE_W-1:0] to_reg;
    logic [ROW_W-1:0]           ram_rdata;

    // copy of the write that lands on the same edge as a read
    logic                       fwd_en_reg;
    logic [oct_pkg::NODE_W-1:0] fwd_addr_reg;
    logic [ROW_W-1:0]           fwd_data_reg;

    logic [ROW_W-1:0]           valid_reg;
    logic [ROW_W-1:0]           pivot_reg;
    logic [AW-1:0]              pivot_k_reg;

    logic                       out_valid_reg;
    logic [oct_pkg::NODE_W-1:0] out_index_reg;
    logic [oct_pkg::OUT_W-1:0]  out_bits_reg;
    logic                       out_last_reg;

    logic [ROW_W-1:0]           base_row;
    logic [ROW_W-1:0]           masked_row;
    logic [ROW_W-1:0]           sweep_row;
    logic [ROW_W-1:0]           to_onehot;
    logic [ROW_W-1:0]           colmask;
    logic                       fwd_hit;

    logic                       wr_en;
    logic [oct_pkg::NODE_W-1:0] wr_addr;
    logic [ROW_W-1:0]           wr_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = cmd.in_ready;
    assign in_fire   = in_valid && cmd.in_ready;
    assign out_busy  = out_valid_reg && !out_ready;

    // Effective last node index: a count of zero acts as one, saturate at ROW_W.
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            nlast_cur = '0;
        end
        else if (node_count_reg > oct_pkg::CNT_W'(ROW_W))
        begin
            nlast_cur = oct_pkg::NODE_W'(ROW_W - 1);
        end
        else
        begin
            nlast_cur = oct_pkg::NODE_W'(node_count_reg - 1'b1);
        end
    end

    // Drop arcs that name a node outside the count in force.
    assign arc_ok = (from_node <= nlast_cur) && (to_node <= nlast_cur);

    oct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .has_arc   (has_arc),
        .arc_ok    (arc_ok),
        .last_arc  (last_arc),
        .from_node (from_node),
        .nlast     (nlast_reg),
        .out_busy  (out_busy),
        .cmd       (cmd)
    );

    oct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr[AW-1:0]),
        .wdata (wr_data),
        .raddr (cmd.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Column mask and target bit, one compare per column.
    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            colmask[j]   = (oct_pkg::NODE_W'(j) <= nlast_reg);
            to_onehot[j] = (to_reg == oct_pkg::NODE_W'(j));
        end
    end

    // Returned row: take the write that hit this row on the read edge, else the
    // RAM, and treat a row not written since the last clear as zero.
    assign fwd_hit    = fwd_en_reg && (fwd_addr_reg == rd_addr_reg);
    assign base_row   = fwd_hit ? fwd_data_reg : (rd_valid_reg ? ram_rdata : '0);
    assign masked_row = base_row & colmask;
    // Warshall step: if row i reaches pivot k, it reaches all that k reaches.
    assign sweep_row  = masked_row | (masked_row[pivot_k_reg] ? pivot_reg : '0);

    // Write back the modified row in the cycle after its read.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = sweep_row;
        case (rd_tag_reg)
            oct_pkg::TAG_ARC:
            begin
                wr_en   = 1'b1;
                wr_data = base_row | to_onehot;
            end
            oct_pkg::TAG_SWEEP:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= oct_pkg::NODE_COUNT_RST;
            nlast_reg      <= '0;
            rd_tag_reg     <= oct_pkg::TAG_NONE;
            fwd_en_reg     <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= node_count;
            end
            // Hold the count in force at the closing request for the whole closure.
            if (in_fire && last_arc)
            begin
                nlast_reg <= nlast_cur;
            end
            rd_tag_reg <= cmd.tag;
            fwd_en_reg <= wr_en;
            if (cmd.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (rd_tag_reg == oct_pkg::TAG_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        rd_addr_reg  <= cmd.addr;
        rd_valid_reg <= valid_reg[cmd.addr[AW-1:0]];
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
        if (in_fire)
        begin
            to_reg <= to_node;
        end
        if (rd_tag_reg == oct_pkg::TAG_PIVOT)
        begin
            pivot_reg   <= masked_row;
            pivot_k_reg <= rd_addr_reg[AW-1:0];
        end
        if (rd_tag_reg == oct_pkg::TAG_EMIT)
        begin
            out_index_reg <= rd_addr_reg;
            out_bits_reg  <= oct_pkg::OUT_W'(masked_row);
            out_last_reg  <= (rd_addr_reg == nlast_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = out_index_reg;
    assign row_bits  = out_bits_reg;
    assign last_row  = out_last_reg;

endmodule

// ===== rtl/oct_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the transitive closure block, bound to the top level.
module oct_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        last_arc,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [oct_pkg::NODE_W-1:0]  row_index,
    input logic [oct_pkg::OUT_W-1:0]   row_bits,
    input logic                        last_row
);

    logic [oct_pkg::NODE_W-1:0] exp_idx_reg;

    // Track the row number that should come next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            exp_idx_reg <= last_row ? '0 : exp_idx_reg + 1'b1;
        end
    end

    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_bits) && $stable(row_index))
        else $error("row changed while stalled");

    a_close_stops_input : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_arc |=> !in_ready)
        else $error("request taken while closure starts");

    a_row_order : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index == exp_idx_reg)
        else $error("rows out of order");

    a_emit_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_row |=> !in_ready)
        else $error("request taken before the last row");

endmodule

bind order_constraint_transitive_closure oct_checker u_oct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_arc  (last_arc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last_row  (last_row)
);

// ===== tb/sv/tb_order_constraint_transitive_closure.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: arc sets in, closure rows checked against a Warshall predictor.
module tb_order_constraint_transitive_closure;

    localparam int MAX_NODES    = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Long enough for the worst closure plus the row drain; wait that long for strays.
    localparam int DRAIN_CYCLES = 1200;
    localparam int IDLE_PCT     = 26;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 85;

    // One reachability row as the block presents it.
    typedef struct packed {
        logic [oct_pkg::NODE_W-1:0] index;
        logic [oct_pkg::OUT_W-1:0]  bits;
        logic                       last;
    } row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [oct_pkg::CNT_W-1:0]   node_count;
    logic                        in_valid;
    logic                        in_ready;
    logic                        has_arc;
    logic [oct_pkg::NODE_W-1:0]  from_node;
    logic [oct_pkg::NODE_W-1:0]  to_node;
    logic                        last_arc;
    logic                        out_valid;
    logic                        out_ready;
    logic [oct_pkg::NODE_W-1:0]  row_index;
    logic [oct_pkg::OUT_W-1:0]   row_bits;
    logic                        last_row;

    // Predictor state: precedence matrix and the node count in force.
    logic [oct_pkg::OUT_W-1:0]   prec_matrix [MAX_NODES];
    logic [oct_pkg::CNT_W-1:0]   set_size_reg;
    row_t                        pending_rows [$];

    int  mismatches;
    int  rows_checked;
    int  sets_closed;
    int  config_writes;
    int  requests_counted;
    int  items_sent;
    int  cycle_count;
    bit  quiet;          // suppress idling on both sides
    int  stall_requests; // bumped by a test to ask for a long receiver hold-off
    int  stall_len;

    order_constraint_transitive_closure #(
        .MAX_NODES (MAX_NODES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .node_count (node_count),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .has_arc    (has_arc),
        .from_node  (from_node),
        .to_node    (to_node),
        .last_arc   (last_arc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_index  (row_index),
        .row_bits   (row_bits),
        .last_row   (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Clamp the register value the way the block does: 0 counts as 1, saturate high.
    function automatic int eff_nodes(logic [oct_pkg::CNT_W-1:0] value);
        int n;
        n = int'(value);
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        if (n > oct_pkg::ROW_LIMIT) n = oct_pkg::ROW_LIMIT;
        return n;
    endfunction

    // Apply one accepted request to the matrix; on a closing request run the
    // full closure, queue one row per node in use and clear the matrix.
    // Return whether the request did anything (stored an arc or closed a set).
    function automatic bit predict_request(logic arc, logic [oct_pkg::NODE_W-1:0] src,
                                           logic [oct_pkg::NODE_W-1:0] dst, logic closes);
        int                        n;
        logic [oct_pkg::OUT_W-1:0] colmask;
        row_t                      r;
        bit                        stored;
        n = eff_nodes(set_size_reg);
        stored = arc && (int'(src) < n) && (int'(dst) < n);
        if (stored)
            prec_matrix[src][dst] = 1'b1;
        if (!closes)
            return stored;
        // Drop columns beyond the count in force now; the count may have shrunk mid-set.
        colmask = {oct_pkg::OUT_W{1'b1}} >> (oct_pkg::OUT_W - n);
        for (int i = 0; i < n; i++)
            prec_matrix[i] &= colmask;
        // Warshall: pivot on every node so chains in any index order are followed.
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                if (prec_matrix[i][k])
                    prec_matrix[i] |= prec_matrix[k];
        for (int i = 0; i < n; i++)
        begin
            r.index = oct_pkg::NODE_W'(i);
            r.bits  = prec_matrix[i];
            r.last  = (i == n - 1);
            pending_rows = {pending_rows, r};
        end
        for (int i = 0; i < MAX_NODES; i++)
            prec_matrix[i] = '0;
        sets_closed++;
        return 1'b1;
    endfunction

    // Offer one request, hold it until taken, then predict its effect.
    task automatic send_request(logic arc, logic [oct_pkg::NODE_W-1:0] src,
                                logic [oct_pkg::NODE_W-1:0] dst, logic closes);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        has_arc   <= arc;
        from_node <= src;
        to_node   <= dst;
        last_arc  <= closes;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (predict_request(arc, src, dst, closes))
            requests_counted++;
    endtask

    // Write the node count only once the block is quiet: every expected row
    // taken, then a short pause so the block is back to loading.
    task automatic write_set_size(logic [oct_pkg::CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid  <= 1'b1;
        node_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_size_reg = value;
        config_writes++;
    endtask

    // Reset count of 32: a cycle that runs against index order, a self arc,
    // an item with no arc, and an arc carried on the closing request.
    task automatic test_reset_count();
        send_request(1'b1, 5'd31, 5'd0,  1'b0);
        send_request(1'b1, 5'd0,  5'd15, 1'b0);
        send_request(1'b1, 5'd15, 5'd31, 1'b0);
        send_request(1'b1, 5'd5,  5'd5,  1'b0);
        send_request(1'b0, 5'd31, 5'd31, 1'b0);
        send_request(1'b1, 5'd10, 5'd31, 1'b1);
    endtask

    // Register extremes: 0 acts as one node, 63 saturates to the maximum,
    // and with one node an arc to node 1 is ignored before an empty close.
    task automatic test_count_limits();
        write_set_size(6'd0);
        send_request(1'b1, 5'd0, 5'd0, 1'b1);
        write_set_size(6'd63);
        send_request(1'b1, 5'd31, 5'd30, 1'b0);
        send_request(1'b1, 5'd30, 5'd29, 1'b1);
        write_set_size(6'd1);
        send_request(1'b1, 5'd0, 5'd1, 1'b0);
        send_request(1'b0, 5'd0, 5'd0, 1'b1);
    endtask

    // Five nodes: arcs touching node 5 or above must vanish; a falling chain
    // then rising arc must still close fully.
    task automatic test_out_of_range();
        write_set_size(6'd5);
        send_request(1'b1, 5'd4, 5'd5, 1'b0);
        send_request(1'b1, 5'd6, 5'd2, 1'b0);
        send_request(1'b1, 5'd4, 5'd2, 1'b0);
        send_request(1'b1, 5'd2, 5'd0, 1'b0);
        send_request(1'b1, 5'd0, 5'd3, 1'b0);
        send_request(1'b0, 5'd0, 5'd0, 1'b1);
    endtask

    // Shrink the count in the middle of a set: arcs already stored on
    // nodes past the new count must be dropped at closure.
    task automatic test_count_change_mid_set();
        write_set_size(6'd8);
        send_request(1'b1, 5'd7, 5'd6, 1'b0);
        send_request(1'b1, 5'd6, 5'd1, 1'b0);
        send_request(1'b1, 5'd1, 5'd2, 1'b0);
        write_set_size(6'd4);
        send_request(1'b1, 5'd3, 5'd0, 1'b1);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering small sets, so rows back up and the input stalls.
    task automatic test_back_pressure();
        write_set_size(6'd3);
        quiet     = 1'b1;
        stall_len = 300;
        stall_requests++;
        repeat (4)
        begin
            send_request(1'b1, 5'd0, 5'd1, 1'b0);
            send_request(1'b1, 5'd1, 5'd2, 1'b1);
        end
        quiet = 1'b0;
    endtask

    // Random phases: pick a count (mostly small), then a few sets made
    // mostly of in-range arcs with some noise mixed in.
    task automatic test_random_sets();
        int                        start;
        int                        phase;
        int                        pick;
        int                        n;
        int                        len;
        logic [oct_pkg::CNT_W-1:0] value;
        logic                      closes;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                value = oct_pkg::CNT_W'($urandom_range(1, 8));
            else if (pick < 80)
                value = oct_pkg::CNT_W'($urandom_range(9, 31));
            else if (pick < 90)
                value = 6'd32;
            else if (pick < 94)
                value = 6'd0;
            else
                value = oct_pkg::CNT_W'($urandom_range(33, 63));
            write_set_size(value);
            phase++;
            quiet = (phase == 3);
            n = eff_nodes(value);
            repeat ($urandom_range(2, 4))
            begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                begin
                    closes = (j == len - 1);
                    if ($urandom_range(0, 99) < 85)
                        send_request(closes ? 1'($urandom_range(0, 1)) : 1'b1,
                                     oct_pkg::NODE_W'($urandom_range(0, n - 1)),
                                     oct_pkg::NODE_W'($urandom_range(0, n - 1)),
                                     closes);
                    else
                        send_request(1'($urandom_range(0, 1)),
                                     oct_pkg::NODE_W'($urandom_range(0, 31)),
                                     oct_pkg::NODE_W'($urandom_range(0, 31)), closes);
                end
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver: check each taken row against the oldest expectation, then
    // decide readiness for the next cycle (hold-off first, else random idling).
    initial
    begin
        int   stalls_seen;
        int   stall_left;
        row_t got;
        row_t want;
        stalls_seen = 0;
        stall_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.index = row_index;
                got.bits  = row_bits;
                got.last  = last_row;
                if (pending_rows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected row: index %0d bits %08h last %0b",
                                 got.index, got.bits, got.last);
                end
                else
                begin
                    want = pending_rows.pop_front();
                    rows_checked++;
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("row mismatch: expected %0d/%08h/%0b got %0d/%08h/%0b",
                                     want.index, want.bits, want.last,
                                     got.index, got.bits, got.last);
                    end
                end
            end
            if (stall_requests != stalls_seen)
            begin
                stalls_seen = stall_requests;
                stall_left  = stall_len;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if the block hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        mismatches       = 0;
        rows_checked     = 0;
        sets_closed      = 0;
        config_writes    = 0;
        requests_counted = 0;
        items_sent       = 0;
        quiet            = 1'b0;
        stall_requests   = 0;
        stall_len        = 0;
        set_size_reg     = oct_pkg::NODE_COUNT_RST;
        for (int i = 0; i < MAX_NODES; i++)
            prec_matrix[i] = '0;

        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        node_count <= oct_pkg::NODE_COUNT_RST;
        in_valid   <= 1'b0;
        has_arc    <= 1'b0;
        from_node  <= '0;
        to_node    <= '0;
        last_arc   <= 1'b0;
        out_ready  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_count_limits();
        test_out_of_range();
        test_count_change_mid_set();
        test_back_pressure();
        test_random_sets();

        // Drain: wait out every expected row, then watch for strays.
        in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_rows.size() != 0)
        begin
            mismatches += pending_rows.size();
            $display("%0d expected rows never arrived", pending_rows.size());
        end

        $display("Closed %0d arc sets over %0d node-count writes, %0d rows compared.",
                 sets_closed, config_writes, rows_checked);
        $display("%0d requests sent, %0d took effect; %0d mismatches in %0d cycles.",
                 items_sent, requests_counted, mismatches, cycle_count);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== order_constraint_transitive_closure.f =====
rtl/oct_pkg.sv
rtl/oct_ram.sv
rtl/oct_ctrl.sv
rtl/order_constraint_transitive_closure.sv
rtl/oct_checker.sv
tb/sv/tb_order_constraint_transitive_closure.sv
